// ===== rtl/core/gsif_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the gradient select fusion block
// no dependencies

package gsif_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int SQRT_STEPS = 15;
  localparam int RAD_W      = 30;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_WORK
  } front_state_t;

  // result side data carried along the back pipeline
  typedef struct packed {
    logic [47:0]      centre;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pay_t;

  // one queued window pair, [column][row] of gray bytes
  typedef struct packed {
    logic [4:0][4:0][7:0] win_a;
    logic [4:0][4:0][7:0] win_b;
    pay_t                 pay;
  } job_t;

endpackage

// ===== rtl/core/gsif_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front and back
// depends on gsif_pkg

module gsif_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gsif_pkg::job_t push_data,
  output logic          room,
  input  logic          pop,
  output logic          not_empty,
  output gsif_pkg::job_t head
);
  import gsif_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign room      = count < (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/gsif_front.sv =====
`timescale 1ns / 1ps
// front end: position counters, gray conversion, line memory, windows
// depends on gsif_pkg

module gsif_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gsif_pkg::FW_W-1:0]   frame_width,
  input  logic [gsif_pkg::FH_W-1:0]   frame_height,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        start_of_frame,
  input  logic [7:0]                  blue_a,
  input  logic [7:0]                  green_a,
  input  logic [7:0]                  red_a,
  input  logic [7:0]                  blue_b,
  input  logic [7:0]                  green_b,
  input  logic [7:0]                  red_b,
  input  logic                        q_room,
  output logic                        q_push,
  output gsif_pkg::job_t              q_data
);
  import gsif_pkg::*;

  localparam int WORD_W = 32 + 32 + 96;

  function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [21:0] s;
    s = 22'(r) * 22'd4899 + 22'(g) * 22'd9617 + 22'(b) * 22'd1868 + 22'd8192;
    return s[21:14];
  endfunction

  front_state_t state;
  front_state_t state_next;

  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [FW_W-1:0]  wc;
  logic [FH_W-1:0]  hc;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [FW_W-1:0]  c1;
  logic [FH_W-1:0]  r1;
  logic             accept;

  logic [ROW_W-1:0] r_q;
  logic [COL_W-1:0] c_q;
  logic [7:0]       ga_q;
  logic [7:0]       gb_q;
  logic [47:0]      cur_q;
  logic             last_q;

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;

  logic [4:0][4:0][7:0] win_a;
  logic [4:0][4:0][7:0] win_b;
  logic [4:0][4:0][7:0] win_a_next;
  logic [4:0][4:0][7:0] win_b_next;
  logic [1:0][47:0]     cdelay;
  logic [3:0][7:0]      la;
  logic [3:0][7:0]      lb;
  logic [1:0][47:0]     lc;
  logic [47:0]          old_c;
  logic                 emit;

  // clamp frame size
  always_comb begin
    wc = frame_width;
    if (frame_width < FW_W'(5)) wc = FW_W'(5);
    else if (frame_width > FW_W'(MAX_WIDTH)) wc = FW_W'(MAX_WIDTH);
    hc = frame_height;
    if (frame_height < FH_W'(5)) hc = FH_W'(5);
    else if (frame_height > FH_W'(MAX_HEIGHT)) hc = FH_W'(MAX_HEIGHT);
  end

  // position of the incoming word
  always_comb begin
    r0 = start_of_frame ? '0 : row_count;
    c0 = start_of_frame ? '0 : col_count;
    if (FH_W'(r0) >= hc) r0 = '0;
    if (FW_W'(c0) >= wc) c0 = '0;
    c1 = FW_W'(c0) + 1'b1;
    r1 = FH_W'(r0) + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FRONT_IDLE: if (accept) state_next = FRONT_WORK;
      FRONT_WORK: state_next = FRONT_IDLE;
      default:    state_next = FRONT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    case (state)
      FRONT_IDLE: in_stall = !q_room;
      FRONT_WORK: in_stall = 1'b1;
      default:    in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FRONT_IDLE;
      row_count <= '0;
      col_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (c1 >= wc) begin
          col_count <= '0;
          row_count <= (r1 >= hc) ? '0 : r1[ROW_W-1:0];
        end else begin
          col_count <= c1[COL_W-1:0];
          row_count <= r0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_q    <= r0;
      c_q    <= c0;
      ga_q   <= to_gray(blue_a, green_a, red_a);
      gb_q   <= to_gray(blue_b, green_b, red_b);
      cur_q  <= {red_b, green_b, blue_b, red_a, green_a, blue_a};
      last_q <= (FH_W'(r0) == hc - 1'b1) && (FW_W'(c0) == wc - 1'b1);
      rdata  <= mem[c0];
    end
  end

  // window shift and line update
  always_comb begin
    {la, lb, lc} = rdata;
    old_c = lc[r_q[0]];
    win_a_next = win_a;
    win_b_next = win_b;
    for (int k = 0; k < 4; k++) begin
      win_a_next[k] = win_a[k+1];
      win_b_next[k] = win_b[k+1];
    end
    for (int i = 0; i < 4; i++) begin
      win_a_next[4][i] = la[2'(r_q[1:0] + 2'(i))];
      win_b_next[4][i] = lb[2'(r_q[1:0] + 2'(i))];
    end
    win_a_next[4][4] = ga_q;
    win_b_next[4][4] = gb_q;
    la[r_q[1:0]] = ga_q;
    lb[r_q[1:0]] = gb_q;
    lc[r_q[0]]   = cur_q;
    wdata = {la, lb, lc};
  end

  assign emit   = (state == FRONT_WORK) && (r_q >= ROW_W'(4)) && (c_q >= COL_W'(4));
  assign q_push = emit;

  always_comb begin
    q_data.win_a       = win_a_next;
    q_data.win_b       = win_b_next;
    q_data.pay.centre  = cdelay[1];
    q_data.pay.row     = r_q - ROW_W'(2);
    q_data.pay.col     = c_q - COL_W'(2);
    q_data.pay.last    = last_q;
  end

  always_ff @(posedge clk) begin
    if (state == FRONT_WORK) begin
      mem[c_q]  <= wdata;
      win_a     <= win_a_next;
      win_b     <= win_b_next;
      cdelay[1] <= cdelay[0];
      cdelay[0] <= old_c;
    end
  end

endmodule

// ===== rtl/core/gsif_back.sv =====
`timescale 1ns / 1ps
// back end: sobel gradients, pipelined square root, selection
// depends on gsif_pkg

module gsif_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_not_empty,
  input  gsif_pkg::job_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gsif_pkg::ROW_W-1:0]   out_row,
  output logic [gsif_pkg::COL_W-1:0]   out_col,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_red,
  output logic                         from_second,
  output logic                         last_of_frame
);
  import gsif_pkg::*;

  localparam int NST = SQRT_STEPS + 1;

  typedef struct packed {
    logic [RAD_W-1:0] va;
    logic [RAD_W-1:0] ra;
    logic [RAD_W-1:0] vb;
    logic [RAD_W-1:0] rb;
    pay_t             pay;
  } root_t;

  // smoothing column sum (1 4 6 4 1)
  function automatic logic [11:0] smooth(input logic [4:0][7:0] p);
    return 12'(p[0]) + (12'(p[1]) << 2) + 12'(p[2]) * 12'd6 + (12'(p[3]) << 2) + 12'(p[4]);
  endfunction

  // derivative column sum (1 2 0 -2 -1)
  function automatic logic signed [10:0] deriv(input logic [4:0][7:0] p);
    return $signed(11'(p[0])) + $signed(11'(p[1]) << 1)
         - $signed(11'(p[3]) << 1) - $signed(11'(p[4]));
  endfunction

  function automatic logic [13:0] abs15(input logic signed [14:0] v);
    return v[14] ? 14'(-v) : v[13:0];
  endfunction

  logic en;

  logic             v1;
  logic [4:0][11:0] sxa, sxb;
  logic [4:0][10:0] dya, dyb;
  pay_t             p1;

  logic             v2;
  logic [13:0]      axa, aya, axb, ayb;
  pay_t             p2;

  logic             v3;
  logic [27:0]      qxa, qya, qxb, qyb;
  pay_t             p3;

  root_t            st [NST];
  logic [NST-1:0]   sv;

  logic signed [14:0] gxa, gya, gxb, gyb;

  // whole pipeline holds while the output word waits
  assign en    = !(out_valid && out_stall);
  assign q_pop = en && q_not_empty;

  always_comb begin
    gxa = 15'(sxa[0]) + (15'(sxa[1]) << 1) - (15'(sxa[3]) << 1) - 15'(sxa[4]);
    gxb = 15'(sxb[0]) + (15'(sxb[1]) << 1) - (15'(sxb[3]) << 1) - 15'(sxb[4]);
    gya = 15'($signed(dya[0])) + 15'($signed(dya[1])) * 15'sd4 + 15'($signed(dya[2])) * 15'sd6
        + 15'($signed(dya[3])) * 15'sd4 + 15'($signed(dya[4]));
    gyb = 15'($signed(dyb[0])) + 15'($signed(dyb[1])) * 15'sd4 + 15'($signed(dyb[2])) * 15'sd6
        + 15'($signed(dyb[3])) * 15'sd4 + 15'($signed(dyb[4]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      sv[0] <= 1'b0;
    end else if (en) begin
      v1 <= q_not_empty;
      v2 <= v1;
      v3 <= v2;
      sv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        sxa[k] <= smooth(q_head.win_a[k]);
        sxb[k] <= smooth(q_head.win_b[k]);
        dya[k] <= deriv(q_head.win_a[k]);
        dyb[k] <= deriv(q_head.win_b[k]);
      end
      p1  <= q_head.pay;
      axa <= abs15(gxa);
      aya <= abs15(gya);
      axb <= abs15(gxb);
      ayb <= abs15(gyb);
      p2  <= p1;
      qxa <= 28'(axa) * 28'(axa);
      qya <= 28'(aya) * 28'(aya);
      qxb <= 28'(axb) * 28'(axb);
      qyb <= 28'(ayb) * 28'(ayb);
      p3  <= p2;
      st[0].va  <= RAD_W'(qxa) + RAD_W'(qya);
      st[0].vb  <= RAD_W'(qxb) + RAD_W'(qyb);
      st[0].ra  <= '0;
      st[0].rb  <= '0;
      st[0].pay <= p3;
    end
  end

  // one root digit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [RAD_W-1:0] ta, tb;
    assign ta = st[j].ra + BIT;
    assign tb = st[j].rb + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (st[j].va >= ta) begin
          st[j+1].va <= st[j].va - ta;
          st[j+1].ra <= (st[j].ra >> 1) + BIT;
        end else begin
          st[j+1].va <= st[j].va;
          st[j+1].ra <= st[j].ra >> 1;
        end
        if (st[j].vb >= tb) begin
          st[j+1].vb <= st[j].vb - tb;
          st[j+1].rb <= (st[j].rb >> 1) + BIT;
        end else begin
          st[j+1].vb <= st[j].vb;
          st[j+1].rb <= st[j].rb >> 1;
        end
        st[j+1].pay <= st[j].pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && sv[NST-1]) begin
      from_second   <= st[NST-1].rb > st[NST-1].ra;
      out_row       <= st[NST-1].pay.row;
      out_col       <= st[NST-1].pay.col;
      last_of_frame <= st[NST-1].pay.last;
      if (st[NST-1].rb > st[NST-1].ra) begin
        {out_red, out_green, out_blue} <= st[NST-1].pay.centre[47:24];
      end else begin
        {out_red, out_green, out_blue} <= st[NST-1].pay.centre[23:0];
      end
    end
  end

endmodule

// ===== rtl/core/gradient_select_image_fusion.sv =====
`timescale 1ns / 1ps
// top level of the gradient select fusion block
// depends on gsif_pkg, gsif_front, gsif_queue, gsif_back

// Fuses two aligned BGR frames streamed in raster order, one pixel pair per
// input word. For each pixel pair the front reads the line memory entry for
// its column (four gray lines of each image plus two colour lines, packed in
// one word) and then writes it back, and takes no new word until the write
// back is done. A 5x5 Sobel gradient is formed for both images, its magnitude
// goes through a fifteen stage square root pipeline, and for every pixel two
// in from each edge the colour of the sharper image comes out (ties pick the
// first image). A result comes out only once the pixel two lines and two
// columns further on is taken. Border pixels give no output word. Frame size
// must be written on the config port only while idle; the block does not
// enforce this. Out of range values are clamped to 5..2048 by 5..4096.

module gradient_select_image_fusion (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gsif_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsif_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             start_of_frame,
  input  logic [7:0]                       blue_a,
  input  logic [7:0]                       green_a,
  input  logic [7:0]                       red_a,
  input  logic [7:0]                       blue_b,
  input  logic [7:0]                       green_b,
  input  logic [7:0]                       red_b,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gsif_pkg::ROW_W-1:0]       out_row,
  output logic [gsif_pkg::COL_W-1:0]       out_col,
  output logic [7:0]                       out_blue,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_red,
  output logic                             from_second,
  output logic                             last_of_frame
);
  import gsif_pkg::*;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  // queue wires
  logic q_push;
  logic q_room;
  logic q_pop;
  logic q_not_empty;
  job_t q_in;
  job_t q_head;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(1136);
      frame_height <= FH_W'(852);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // front: counters, gray, line memory, windows
  gsif_front u_front (
    .clk            (clk),
    .rst            (rst),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .start_of_frame (start_of_frame),
    .blue_a         (blue_a),
    .green_a        (green_a),
    .red_a          (red_a),
    .blue_b         (blue_b),
    .green_b        (green_b),
    .red_b          (red_b),
    .q_room         (q_room),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  // windows waiting for the gradient pipeline
  gsif_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .room      (q_room),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: gradients, root, selection, output register
  gsif_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .from_second   (from_second),
    .last_of_frame (last_of_frame)
  );

endmodule
